FILE: src/idtp_pkg.sv
package idtp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned PosW   = 4;
	localparam int unsigned YearW  = 14;
	localparam int unsigned PairW  = 7;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;

	localparam logic [PosW-1:0] TextLen  = 4'd10;
	localparam logic [PosW-1:0] PosFinal = 4'd9;
	localparam logic [PosW-1:0] PosSep1  = 4'd4;
	localparam logic [PosW-1:0] PosSep2  = 4'd7;
	localparam logic [PosW-1:0] PosYrLo  = 4'd2;

	localparam logic [CharW-1:0] ChDash  = 8'h2d;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;

	localparam logic [YearW-1:0] YearMin = 14'd1900;
	localparam logic [YearW-1:0] YearMax = 14'd9999;
	localparam logic [PairW-1:0] MonthMax = 7'd12;

	localparam int unsigned DataOutW = 24;

	typedef logic [DayW-1:0] day_t;

	// days in a month, zero for a month code outside 1..12
	function automatic day_t days_in_month(input logic [MonthW-1:0] m, input logic leap);
		day_t d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2: d = leap ? 5'd29 : 5'd28;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: src/iso_date_text_parser.sv
// channel  | direction | handshake             | payload
// s_axis   | in        | s_tvalid / s_tready   | s_tdata = char_code, s_tlast = last_char
// m_axis   | out       | m_tvalid / m_tready   | m_tdata = date_ok, year, month, day
//
// one character per cycle unless a last character stalls: an input register, then the
// parse update and the calendar check in one pass into the result register
// a result appears only for a character flagged last
// arst_n clears the position, accumulators, error flag and both valid bits
// characters that give no result pass while the output waits; only a last
// character stalls behind an untaken result
module iso_date_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tlast,  // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [0] date_ok, [14:1] year_out, [18:15] month_out,
	                              // [23:19] day_out
);

	logic                            valid_s1;
	logic [idtp_pkg::CharW-1:0]      char_s1;
	logic                            last_s1;
	logic                            fire_s1;

	logic [idtp_pkg::PosW-1:0]       pos_q;
	logic [idtp_pkg::YearW-1:0]      year_q;
	logic [idtp_pkg::PairW-1:0]      yhi_q;
	logic [idtp_pkg::PairW-1:0]      ylo_q;
	logic [idtp_pkg::PairW-1:0]      month_q;
	logic [idtp_pkg::PairW-1:0]      day_q;
	logic                            bad_q;

	logic [idtp_pkg::DataOutW-1:0]   data_q;
	logic                            valid_q;

	logic                            is_digit;
	logic [3:0]                      digit;
	logic [idtp_pkg::PosW-1:0]       pos_n;
	logic [idtp_pkg::YearW-1:0]      year_n;
	logic [idtp_pkg::PairW-1:0]      yhi_n;
	logic [idtp_pkg::PairW-1:0]      ylo_n;
	logic [idtp_pkg::PairW-1:0]      month_n;
	logic [idtp_pkg::PairW-1:0]      day_n;
	logic                            bad_n;
	logic                            at_end;
	logic                            leap;
	idtp_pkg::day_t                  dim;
	logic                            ok;

	assign fire_s1  = valid_s1 && (!last_s1 || !valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	assign is_digit = (char_s1 >= idtp_pkg::ChZero) && (char_s1 <= idtp_pkg::ChNine);
	assign digit    = 4'(char_s1 - idtp_pkg::ChZero);

	always_comb begin
		pos_n   = pos_q;
		year_n  = year_q;
		yhi_n   = yhi_q;
		ylo_n   = ylo_q;
		month_n = month_q;
		day_n   = day_q;
		bad_n   = bad_q;
		at_end  = 1'b0;
		if (pos_q >= idtp_pkg::TextLen) begin
			bad_n = 1'b1;
		end else begin
			at_end = (pos_q == idtp_pkg::PosFinal);
			pos_n  = pos_q + 4'd1;
			if (pos_q == idtp_pkg::PosSep1 || pos_q == idtp_pkg::PosSep2) begin
				if (char_s1 != idtp_pkg::ChDash)
					bad_n = 1'b1;
			end else if (!is_digit) begin
				bad_n = 1'b1;
			end else if (pos_q < idtp_pkg::PosSep1) begin
				// x*10 as shift and add
				year_n = (year_q << 3) + (year_q << 1) + {10'd0, digit};
				if (pos_q < idtp_pkg::PosYrLo)
					yhi_n = (yhi_q << 3) + (yhi_q << 1) + {3'd0, digit};
				else
					ylo_n = (ylo_q << 3) + (ylo_q << 1) + {3'd0, digit};
			end else if (pos_q < idtp_pkg::PosSep2) begin
				month_n = (month_q << 3) + (month_q << 1) + {3'd0, digit};
			end else begin
				day_n = (day_q << 3) + (day_q << 1) + {3'd0, digit};
			end
		end
	end

	// year and month are complete before the final character, only the day moves
	assign leap = (ylo_q == '0) ? (yhi_q[1:0] == 2'd0) : (ylo_q[1:0] == 2'd0);
	assign dim  = idtp_pkg::days_in_month(month_q[idtp_pkg::MonthW-1:0], leap);
	assign ok   = at_end && !bad_n
		&& (year_q >= idtp_pkg::YearMin) && (year_q <= idtp_pkg::YearMax)
		&& (month_q != '0) && (month_q <= idtp_pkg::MonthMax)
		&& (day_n != '0) && (day_n <= {2'd0, dim});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			year_q  <= '0;
			yhi_q   <= '0;
			ylo_q   <= '0;
			month_q <= '0;
			day_q   <= '0;
			bad_q   <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				year_q  <= '0;
				yhi_q   <= '0;
				ylo_q   <= '0;
				month_q <= '0;
				day_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				year_q  <= year_n;
				yhi_q   <= yhi_n;
				ylo_q   <= ylo_n;
				month_q <= month_n;
				day_q   <= day_n;
				bad_q   <= bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			data_q <= ok ? {day_n[idtp_pkg::DayW-1:0], month_q[idtp_pkg::MonthW-1:0],
				year_q, 1'b1} : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= idtp_pkg::TextLen)
		else $error("character position beyond saturation");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q[0]) |-> (data_q[23:1] == '0))
		else $error("invalid result carries nonzero fields");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (pos_q == '0 && !bad_q && year_q == '0))
		else $error("state not cleared after final character");

	a_ok_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && data_q[0]) |-> (data_q[18:15] != '0 && data_q[18:15] <= 4'd12
			&& data_q[23:19] != '0))
		else $error("accepted date outside month or day range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> valid_q)
		else $error("final character gave no result");
`endif

endmodule
